[design/bcs_pkg.sv]
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared codes, widths and types for the buzzer cadence sequencer.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 16;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  localparam logic CFG_TIMER_CLOCK = 1'b0;
  localparam logic CFG_SOUND_OFF   = 1'b1;

  localparam logic [DIVIDEND_W-1:0] TIMER_CLOCK_RESET = 32'd14000000;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

[design/beep_cadence_sequencer_top.sv]
// ----------------------------------------------------------------------------
// beep_cadence_sequencer_top
// Buzzer on/off cadence controller: start, tick and stop beats drive the
// tone timer settings, volume pins and cadence counters.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  s_      | in  | s_tvalid/tready  | tuser: kind; tdata: hz, on, off, total, level
//  m_      | out | m_tvalid/tready  | tdata: status bits, period, compare
//  cfg_    | in  | cfg_valid/ready  | cfg_index, cfg_data
//
// Tick, stop, ignored start and zero-frequency start beats go from ST_IDLE to
// ST_PUSH, which registers the result; the next beat is taken back in ST_IDLE.
// A start with nonzero frequency passes through ST_DIV first, where the
// 32-step serial divider computes clock / frequency, then through ST_PUSH.
// Synchronous reset clears all sequence state; timer clock reloads 14 MHz.
// A stalled result holds m_tdata; the next beat may be accepted meanwhile.
// ----------------------------------------------------------------------------
module beep_cadence_sequencer_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // tone_hz[15:0], on_ticks[31:16], off_ticks[47:32],
                                 // total_ticks[63:48], level[65:64], zero pad
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // busy_res[0], tone_enable[1], timer_run[2],
                                 // vol_pin_a[3], vol_pin_b[4], period_count[36:5],
                                 // compare_count[67:37], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0] state;

  logic [31:0] timer_clock_hz;
  logic        sound_off;

  logic                   active;
  logic [COUNT_WIDTH-1:0] on_left;
  logic [COUNT_WIDTH-1:0] off_left;
  logic [COUNT_WIDTH-1:0] budget_left;
  logic [COUNT_WIDTH-1:0] on_reload;
  logic [COUNT_WIDTH-1:0] off_reload;
  logic                   tone_en;
  logic                   timer_run;
  logic                   vol_a;
  logic                   vol_b;
  logic [31:0]            period_reg;

  logic [15:0]            in_hz;
  logic [COUNT_WIDTH-1:0] in_on;
  logic [COUNT_WIDTH-1:0] in_off;
  logic [COUNT_WIDTH-1:0] in_total;
  logic [1:0]             in_level;
  logic [1:0]             in_kind;

  logic                   s_fire;
  logic                   m_free;
  logic                   start_ok;
  logic [COUNT_WIDTH-1:0] budget_dec;

  bcs_pkg::div_req_t div_req;
  bcs_pkg::div_rsp_t div_rsp;

  assign in_hz    = s_tdata[15:0];
  assign in_on    = COUNT_WIDTH'(s_tdata[31:16]);
  assign in_off   = COUNT_WIDTH'(s_tdata[47:32]);
  assign in_total = COUNT_WIDTH'(s_tdata[63:48]);
  assign in_level = s_tdata[65:64];
  assign in_kind  = s_tuser;

  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_free    = !m_tvalid || m_tready;

  assign start_ok   = (in_kind == bcs_pkg::KIND_START) && !active && !sound_off;
  assign budget_dec = (budget_left != '0) ? budget_left - 1'b1 : '0;

  assign div_req.start    = s_fire && start_ok && (in_hz != '0);
  assign div_req.dividend = timer_clock_hz;
  assign div_req.divisor  = in_hz;

  bcs_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_clock_hz <= bcs_pkg::TIMER_CLOCK_RESET;
      sound_off      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bcs_pkg::CFG_TIMER_CLOCK: timer_clock_hz <= cfg_data;
        bcs_pkg::CFG_SOUND_OFF:   sound_off      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            state <= div_req.start ? ST_DIV : ST_PUSH;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (m_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s_fire && in_kind == bcs_pkg::KIND_STOP)) begin
      active      <= 1'b0;
      on_left     <= '0;
      off_left    <= '0;
      budget_left <= '0;
      on_reload   <= '0;
      off_reload  <= '0;
      tone_en     <= 1'b0;
      timer_run   <= 1'b0;
      vol_a       <= 1'b0;
      vol_b       <= 1'b0;
      period_reg  <= '0;
    end else begin
      if (state == ST_DIV && div_rsp.done) begin
        period_reg <= div_rsp.quotient;
      end
      if (s_fire && start_ok) begin
        active      <= 1'b1;
        tone_en     <= 1'b1;
        timer_run   <= 1'b1;
        vol_a       <= in_level[1];
        vol_b       <= in_level[0];
        on_left     <= (in_on != '0) ? in_on - 1'b1 : '0;
        off_left    <= in_off;
        on_reload   <= in_on;
        off_reload  <= in_off;
        budget_left <= in_total;
        if (in_hz == '0) begin
          period_reg <= '1;
        end
      end else if (s_fire && in_kind == bcs_pkg::KIND_TICK && active) begin
        budget_left <= budget_dec;
        if (on_left != '0) begin
          on_left <= on_left - 1'b1;
          if (on_left == COUNT_WIDTH'(1)) begin
            tone_en <= 1'b0;
          end
        end else if (budget_dec == '0) begin
          active      <= 1'b0;
          on_left     <= '0;
          off_left    <= '0;
          budget_left <= '0;
          on_reload   <= '0;
          off_reload  <= '0;
          tone_en     <= 1'b0;
          timer_run   <= 1'b0;
          vol_a       <= 1'b0;
          vol_b       <= 1'b0;
          period_reg  <= '0;
        end else if (off_left != '0) begin
          if (off_left == COUNT_WIDTH'(1)) begin
            tone_en  <= 1'b1;
            on_left  <= on_reload;
            off_left <= off_reload;
          end else begin
            off_left <= off_left - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_PUSH && m_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUSH && m_free) begin
      m_tdata <= {4'b0, period_reg[31:1], period_reg, vol_b, vol_a, timer_run, tone_en,
                  active};
    end
  end

endmodule

[design/bcs_divider.sv]
// ----------------------------------------------------------------------------
// bcs_divider
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcs_divider (
  input  logic               clk,
  input  logic               rst,
  input  bcs_pkg::div_req_t  req,
  output bcs_pkg::div_rsp_t  rsp
);

  localparam int CNT_W = $clog2(bcs_pkg::DIVIDEND_W);

  logic                              busy;
  logic                              done;
  logic [CNT_W-1:0]                  cnt;
  logic [bcs_pkg::DIVIDEND_W-1:0]    quo;
  logic [bcs_pkg::DIVISOR_W-1:0]     rem;
  logic [bcs_pkg::DIVISOR_W-1:0]     dvsr;

  logic [bcs_pkg::DIVISOR_W:0]       rem_sh;
  logic [bcs_pkg::DIVISOR_W:0]       rem_sub;
  logic                              ge;
  logic [bcs_pkg::DIVISOR_W-1:0]     rem_next;

  always_comb begin
    rem_sh   = {rem, quo[bcs_pkg::DIVIDEND_W-1]};
    ge       = rem_sh >= {1'b0, dvsr};
    rem_sub  = rem_sh - {1'b0, dvsr};
    rem_next = ge ? rem_sub[bcs_pkg::DIVISOR_W-1:0] : rem_sh[bcs_pkg::DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(bcs_pkg::DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo  <= req.dividend;
      rem  <= '0;
      dvsr <= req.divisor;
    end else if (busy) begin
      quo <= {quo[bcs_pkg::DIVIDEND_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
